FILE: hw/rtl/gmcc_pkg.sv
// Shared constants and types for the grid minimum climb cost search.
// Used by grid_min_climb_cost_search; depends on nothing.
`default_nettype none
package gmcc_pkg;

  localparam int GRID_DIM    = 128;
  localparam int COORD_W     = $clog2(GRID_DIM);
  localparam int IDX_W       = 2 * COORD_W;
  localparam int CELLS       = GRID_DIM * GRID_DIM;
  localparam int HEIGHT_BITS = 12;
  localparam int COST_BITS   = 40;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam logic [COORD_W-1:0] SIDE_MAX = COORD_W'(GRID_DIM - 2);
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIDE  = 2'd0,
    REG_TARGET_ROW = 2'd1,
    REG_TARGET_COL = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_RUN  = 1'b1
  } cmd_e;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_CLEAR = 11'b00000000010,
    ST_SEED  = 11'b00000000100,
    ST_POP   = 11'b00000001000,
    ST_FETCH = 11'b00000010000,
    ST_CUR   = 11'b00000100000,
    ST_NBR   = 11'b00001000000,
    ST_EVAL  = 11'b00010000000,
    ST_SUM   = 11'b00100000000,
    ST_FIN   = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_e;

endpackage
`default_nettype wire

FILE: hw/rtl/grid_min_climb_cost_search.sv
// Top level of the grid minimum climb cost search: height store, cost store,
// in-queue flags, work queue and the sequencer that relaxes them. Uses gmcc_pkg.
`default_nettype none
// A load transaction (tuser 0) writes one cell height. A run transaction
// (tuser 1) first sweeps the cost and flag memories, one entry a cycle, then
// seeds the corner, then relaxes the queue: each popped cell passes ST_POP,
// ST_FETCH and ST_CUR (the target cell only the first two), then each neighbor
// passes ST_NBR and, if on the grid, ST_EVAL and ST_SUM, through one shared
// compare/square/add unit with one read and one write port per memory. The
// run ends in ST_FIN and ST_OUT, which waits while an earlier result is still
// pending, and one result transaction; the input is not ready during a run.
module grid_min_climb_cost_search
  import gmcc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [31:0]          s_axis_tdata,  // cell_row, cell_col, cell_height, zero pad
  input  wire logic                 s_axis_tuser,  // command
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [47:0]               m_axis_tdata   // min_effort, saturated, zero pad
);

  // Configuration registers
  logic [COORD_W-1:0] side_q, trow_q, tcol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= COORD_W'(1);
      trow_q <= COORD_W'(1);
      tcol_q <= COORD_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_SIDE:  side_q <= cfg_data_i;
        REG_TARGET_ROW: trow_q <= cfg_data_i;
        REG_TARGET_COL: tcol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [COORD_W-1:0] n_side, lim;
  assign n_side = (side_q > SIDE_MAX) ? SIDE_MAX : side_q;
  assign lim    = n_side + COORD_W'(1);

  // Input fields
  logic [COORD_W-1:0]     in_row, in_col;
  logic [HEIGHT_BITS-1:0] in_height;
  assign in_row    = s_axis_tdata[6:0];
  assign in_col    = s_axis_tdata[13:7];
  assign in_height = s_axis_tdata[25:14];

  state_e state_q, state_d;
  logic [IDX_W-1:0] head_q, tail_q, sweep_q, idx_q, nidx_q;
  logic [1:0] k_q;
  logic [HEIGHT_BITS-1:0] hcur_q;
  logic [COST_BITS-1:0] cur_q, add_q, costn_q, res_q;
  logic flagn_q, sat_q, out_v_q, res_sat_q;

  // Memory ports
  logic                   h_we, c_we, f_we, q_we;
  logic [IDX_W-1:0]       h_wa, c_wa, f_wa, h_ra, c_ra, f_ra;
  logic [HEIGHT_BITS-1:0] h_wd, h_rd_q;
  logic [COST_BITS-1:0]   c_wd, c_rd_q;
  logic                   f_wd, f_rd_q;
  logic [IDX_W-1:0]       q_wd, q_rd_q;

  logic [HEIGHT_BITS-1:0] height_mem [CELLS];
  logic [COST_BITS-1:0]   cost_mem   [CELLS];
  logic                   flag_mem   [CELLS];
  logic [IDX_W-1:0]       queue_mem  [CELLS];

  always_ff @(posedge clk_i) begin
    if (h_we) height_mem[h_wa] <= h_wd;
    h_rd_q <= height_mem[h_ra];
  end
  always_ff @(posedge clk_i) begin
    if (c_we) cost_mem[c_wa] <= c_wd;
    c_rd_q <= cost_mem[c_ra];
  end
  always_ff @(posedge clk_i) begin
    if (f_we) flag_mem[f_wa] <= f_wd;
    f_rd_q <= flag_mem[f_ra];
  end
  always_ff @(posedge clk_i) begin
    if (q_we) queue_mem[tail_q] <= q_wd;
    q_rd_q <= queue_mem[head_q];
  end

  // Current cell coordinates and the neighbor under test
  logic [COORD_W-1:0] cr, cc, nr_n, nc_n;
  logic [COORD_W:0]   nr, nc;
  logic               nbr_ok;
  assign cr = idx_q[IDX_W-1:COORD_W];
  assign cc = idx_q[COORD_W-1:0];
  always_comb begin
    nr = {1'b0, cr};
    nc = {1'b0, cc};
    nbr_ok = 1'b1;
    case (k_q)
      2'd0: begin
        nc = {1'b0, cc} + (COORD_W+1)'(1);
        nbr_ok = (nc <= {1'b0, lim});
      end
      2'd1: begin
        nr = {1'b0, cr} + (COORD_W+1)'(1);
        nbr_ok = (nr <= {1'b0, lim});
      end
      2'd2: begin
        nc = {1'b0, cc} - (COORD_W+1)'(1);
        nbr_ok = (cc != '0);
      end
      default: begin
        nr = {1'b0, cr} - (COORD_W+1)'(1);
        nbr_ok = (cr != '0);
      end
    endcase
  end
  assign nr_n = nr[COORD_W-1:0];
  assign nc_n = nc[COORD_W-1:0];

  // Border ring reads as height 0
  function automatic logic on_border(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                     logic [COORD_W-1:0] n);
    return (r == '0) || (c == '0) || (r > n) || (c > n);
  endfunction

  logic [COORD_W-1:0] qr, qc;
  assign qr = q_rd_q[IDX_W-1:COORD_W];
  assign qc = q_rd_q[COORD_W-1:0];
  logic [COORD_W-1:0] vr, vc;
  assign vr = nidx_q[IDX_W-1:COORD_W];
  assign vc = nidx_q[COORD_W-1:0];

  // Shared step-cost unit: drop or square of the rise
  logic [HEIGHT_BITS-1:0] hn, diff;
  logic [2*HEIGHT_BITS-1:0] sq;
  assign hn   = on_border(vr, vc, n_side) ? '0 : h_rd_q;
  assign diff = (hn > hcur_q) ? (hn - hcur_q) : (hcur_q - hn);
  assign sq   = diff * diff;

  logic [COST_BITS:0]   sum;
  logic                 ovf;
  logic [COST_BITS-1:0] nxt;
  assign sum = {1'b0, cur_q} + {1'b0, add_q};
  assign ovf = sum[COST_BITS];
  assign nxt = ovf ? COST_MAX : sum[COST_BITS-1:0];

  logic tgt_in;
  assign tgt_in = (trow_q <= lim) && (tcol_q <= lim);

  // Sequencer and memory port selection
  always_comb begin
    state_d = state_q;
    h_we = 1'b0; h_wa = {in_row, in_col}; h_wd = in_height;
    h_ra = q_rd_q;
    c_we = 1'b0; c_wa = sweep_q; c_wd = COST_MAX;
    c_ra = q_rd_q;
    f_we = 1'b0; f_wa = sweep_q; f_wd = 1'b0;
    f_ra = {nr_n, nc_n};
    q_we = 1'b0; q_wd = nidx_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == CMD_RUN) state_d = ST_CLEAR;
          else h_we = 1'b1;
        end
      end
      ST_CLEAR: begin
        c_we = 1'b1;
        f_we = 1'b1;
        if (sweep_q == IDX_W'(CELLS - 1)) state_d = ST_SEED;
      end
      ST_SEED: begin
        c_we = 1'b1; c_wa = '0; c_wd = '0;
        f_we = 1'b1; f_wa = '0; f_wd = 1'b1;
        q_we = 1'b1; q_wd = '0;
        state_d = ST_POP;
      end
      ST_POP: state_d = ST_FETCH;
      ST_FETCH: begin
        f_we = 1'b1; f_wa = q_rd_q; f_wd = 1'b0;
        if (qr == trow_q && qc == tcol_q) begin
          state_d = (head_q + IDX_W'(1) != tail_q) ? ST_POP : ST_FIN;
        end else begin
          state_d = ST_CUR;
        end
      end
      ST_CUR: state_d = ST_NBR;
      ST_NBR: begin
        h_ra = {nr_n, nc_n};
        c_ra = {nr_n, nc_n};
        if (nbr_ok) state_d = ST_EVAL;
        else if (k_q == 2'd3) state_d = (head_q != tail_q) ? ST_POP : ST_FIN;
      end
      ST_EVAL: state_d = ST_SUM;
      ST_SUM: begin
        if (nxt < costn_q) begin
          c_we = 1'b1; c_wa = nidx_q; c_wd = nxt;
          if (!flagn_q) begin
            f_we = 1'b1; f_wa = nidx_q; f_wd = 1'b1;
            q_we = 1'b1;
          end
        end
        if (k_q == 2'd3) begin
          state_d = ((head_q != tail_q) || (nxt < costn_q && !flagn_q)) ? ST_POP : ST_FIN;
        end else begin
          state_d = ST_NBR;
        end
      end
      ST_FIN: begin
        c_ra = {trow_q, tcol_q};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Keep the target cost on the read port while an older result waits
        c_ra = {trow_q, tcol_q};
        if (!out_v_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      sweep_q <= '0;
      k_q     <= '0;
      sat_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && (!out_v_q || m_axis_tready)) out_v_q <= 1'b1;
      else if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          sweep_q <= '0;
          sat_q   <= 1'b0;
          head_q  <= '0;
          tail_q  <= '0;
        end
        ST_CLEAR: sweep_q <= sweep_q + IDX_W'(1);
        ST_SEED: begin
          head_q <= '0;
          tail_q <= IDX_W'(1);
        end
        ST_FETCH: head_q <= head_q + IDX_W'(1);
        ST_CUR:   k_q <= '0;
        ST_NBR: begin
          if (!nbr_ok) k_q <= k_q + 2'd1;
        end
        ST_SUM: begin
          k_q <= k_q + 2'd1;
          if (ovf) sat_q <= 1'b1;
          if (q_we) tail_q <= tail_q + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_FETCH: idx_q <= q_rd_q;
      ST_CUR: begin
        hcur_q <= on_border(cr, cc, n_side) ? '0 : h_rd_q;
        cur_q  <= c_rd_q;
      end
      ST_NBR: nidx_q <= {nr_n, nc_n};
      ST_EVAL: begin
        add_q   <= (hn > hcur_q) ? COST_BITS'(sq) : COST_BITS'(diff);
        costn_q <= c_rd_q;
        flagn_q <= f_rd_q;
      end
      ST_OUT: begin
        if (!out_v_q || m_axis_tready) begin
          res_q     <= tgt_in ? c_rd_q : COST_MAX;
          res_sat_q <= sat_q;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, res_sat_q, res_q};

  // Checks
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output step");
  a_queue_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (head_q == tail_q))
    else $error("work queue not empty while idle");
  a_sat_on_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM && ovf) |=> sat_q)
    else $error("saturation flag missed");
  a_tail_only_enq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NBR || state_q == ST_EVAL) |=> $stable(tail_q))
    else $error("queue tail moved without an enqueue");

endmodule
`default_nettype wire
